// ----- hdl/wsfd_pkg.sv -----
// ----------------------------------------------------------------------------
// wsfd_pkg
// Shared types and codes for the websocket frame deframer: parse phases,
// result kinds and the result bundle passed from the parser to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package wsfd_pkg;

    // header and payload phases, one-hot
    typedef enum logic [5:0] {
        PH_OPCODE = 6'b000001,
        PH_LEN    = 6'b000010,
        PH_EXT_HI = 6'b000100,
        PH_EXT_LO = 6'b001000,
        PH_KEY    = 6'b010000,
        PH_DATA   = 6'b100000
    } phase_t;

    // result kinds
    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_EMPTY = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    // length codes in the second header byte
    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;

    // one parser result
    typedef struct packed {
        logic       vld;
        logic [1:0] kind;
        logic [7:0] data;
        logic [6:0] opcode;
        logic       last;
    } result_t;

endpackage

`default_nettype wire

// ----- hdl/wsfd_parser.sv -----
// ----------------------------------------------------------------------------
// wsfd_parser
// Frame parse state and the per-byte step: header decode, extended length,
// mask key capture and payload unmasking. One byte is consumed per enabled
// cycle and at most one result is produced for it.
// ----------------------------------------------------------------------------
`default_nettype none

module wsfd_parser
    import wsfd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       step_en,
    input  wire logic [7:0] step_byte,
    output result_t         res
);

    phase_t      phase_reg,          phase_next;
    logic [6:0]  held_opcode_reg,    held_opcode_next;
    logic        masked_reg,         masked_next;
    logic [15:0] payload_length_reg, payload_length_next;
    logic [15:0] byte_count_reg,     byte_count_next;
    logic [7:0]  mask_key_reg [4];
    logic [7:0]  mask_key_next [4];
    logic [1:0]  key_index_reg,      key_index_next;

    logic        len_done;
    logic        hdr_done;
    logic [15:0] len_val;
    logic [15:0] count_inc;
    logic [7:0]  unmasked;

    assign count_inc = byte_count_reg + 16'd1;
    assign unmasked  = masked_reg ? (step_byte ^ mask_key_reg[key_index_reg]) : step_byte;

    // per-byte step
    always_comb
    begin
        phase_next          = phase_reg;
        held_opcode_next    = held_opcode_reg;
        masked_next         = masked_reg;
        payload_length_next = payload_length_reg;
        byte_count_next     = byte_count_reg;
        mask_key_next       = mask_key_reg;
        key_index_next      = key_index_reg;
        len_done            = 1'b0;
        hdr_done            = 1'b0;
        len_val             = payload_length_reg;
        res                 = '0;
        res.opcode          = held_opcode_reg;

        case (phase_reg)
            PH_LEN:
            begin
                masked_next = step_byte[7];
                if (step_byte[6:0] == LEN_EXT64)
                begin
                    phase_next = PH_OPCODE;
                    res.vld    = 1'b1;
                    res.kind   = KIND_ERROR;
                    res.last   = 1'b1;
                end
                else if (step_byte[6:0] == LEN_EXT16)
                begin
                    phase_next = PH_EXT_HI;
                end
                else
                begin
                    len_val             = {9'd0, step_byte[6:0]};
                    payload_length_next = len_val;
                    len_done            = 1'b1;
                end
            end
            PH_EXT_HI:
            begin
                payload_length_next = {step_byte, 8'd0};
                phase_next          = PH_EXT_LO;
            end
            PH_EXT_LO:
            begin
                len_val             = payload_length_reg | {8'd0, step_byte};
                payload_length_next = len_val;
                len_done            = 1'b1;
            end
            PH_KEY:
            begin
                mask_key_next[key_index_reg] = step_byte;
                key_index_next               = key_index_reg + 2'd1;
                hdr_done                     = (key_index_reg == 2'd3);
            end
            PH_DATA:
            begin
                key_index_next  = key_index_reg + 2'd1;
                byte_count_next = count_inc;
                res.vld         = 1'b1;
                res.kind        = KIND_DATA;
                res.data        = unmasked;
                if (count_inc == payload_length_reg)
                begin
                    phase_next = PH_OPCODE;
                    res.last   = 1'b1;
                end
            end
            default:
            begin
                held_opcode_next = step_byte[6:0];
                phase_next       = PH_LEN;
            end
        endcase

        // length known: go collect the key, or finish the header
        if (len_done)
        begin
            if (masked_next)
            begin
                key_index_next = 2'd0;
                phase_next     = PH_KEY;
            end
            else
            begin
                hdr_done = 1'b1;
            end
        end

        // header complete: payload follows, or the frame is empty
        if (hdr_done)
        begin
            byte_count_next = 16'd0;
            key_index_next  = 2'd0;
            if (len_val == 16'd0)
            begin
                phase_next = PH_OPCODE;
                res.vld    = 1'b1;
                res.kind   = KIND_EMPTY;
                res.last   = 1'b1;
            end
            else
            begin
                phase_next = PH_DATA;
            end
        end
    end

    // parse state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_OPCODE;
            held_opcode_reg    <= '0;
            masked_reg         <= 1'b0;
            payload_length_reg <= '0;
            byte_count_reg     <= '0;
            mask_key_reg       <= '{default: '0};
            key_index_reg      <= '0;
        end
        else if (step_en)
        begin
            phase_reg          <= phase_next;
            held_opcode_reg    <= held_opcode_next;
            masked_reg         <= masked_next;
            payload_length_reg <= payload_length_next;
            byte_count_reg     <= byte_count_next;
            mask_key_reg       <= mask_key_next;
            key_index_reg      <= key_index_next;
        end
    end

    // a payload phase always has bytes left to deliver
    a_data_bytes_left: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_DATA |-> byte_count_reg < payload_length_reg)
        else $error("payload phase with no bytes left");

    // every payload byte yields a result
    a_data_emits: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_DATA |-> res.vld && res.kind == KIND_DATA)
        else $error("payload byte without a result");

    // errors and empty frames always close the frame
    a_close_last: assert property (@(posedge clk) disable iff (!rst_n)
        res.vld && (res.kind == KIND_ERROR || res.kind == KIND_EMPTY) |-> res.last)
        else $error("frame close without last");

    // a last result sends the parser back to the opcode byte
    a_last_returns: assert property (@(posedge clk) disable iff (!rst_n)
        step_en && res.vld && res.last |=> phase_reg == PH_OPCODE)
        else $error("last result did not end the frame");

endmodule

`default_nettype wire

// ----- hdl/websocket_frame_deframer_unit.sv -----
// ----------------------------------------------------------------------------
// websocket_frame_deframer_unit
// Receive-side websocket frame parser with 16-bit lengths: strips headers,
// unmasks payload bytes and reports empty frames and 64-bit length errors.
// ----------------------------------------------------------------------------
//  channel  | handshake           | payload
//  ---------+---------------------+-------------------------------------------
//  input    | in_valid / in_stall | rx_byte
//  output   | out_valid/out_stall | kind, payload_byte, frame_opcode, last
//
//  one byte per cycle sustained while out_stall is low; a byte is registered
//  on entry and parsed into the output register; header and key bytes
//  produce no output beat, except an empty-frame or 64-bit length error beat
//  asynchronous active-low reset returns the parser to the first header byte
//  out_stall holds the output register, which holds the entry register,
//  which raises in_stall
// ----------------------------------------------------------------------------
`default_nettype none

module websocket_frame_deframer_unit
    import wsfd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] rx_byte,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [1:0]      kind,
    output logic [7:0]      payload_byte,
    output logic [6:0]      frame_opcode,
    output logic            last
);

    logic       s1_valid_reg;
    logic [7:0] s1_byte_reg;
    logic       out_valid_reg;
    logic [1:0] kind_reg;
    logic [7:0] payload_byte_reg;
    logic [6:0] frame_opcode_reg;
    logic       last_reg;

    logic    out_free;
    logic    step_en;
    logic    in_accept;
    result_t res;

    // pipeline handshake
    assign out_free  = !out_valid_reg || !out_stall;
    assign step_en   = s1_valid_reg && out_free;
    assign in_stall  = s1_valid_reg && !out_free;
    assign in_accept = in_valid && !in_stall;

    // entry register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_byte_reg <= rx_byte;
        end
    end

    wsfd_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step_en   (step_en),
        .step_byte (s1_byte_reg),
        .res       (res)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= step_en && res.vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_en && res.vld)
        begin
            kind_reg         <= res.kind;
            payload_byte_reg <= res.data;
            frame_opcode_reg <= res.opcode;
            last_reg         <= res.last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign kind         = kind_reg;
    assign payload_byte = payload_byte_reg;
    assign frame_opcode = frame_opcode_reg;
    assign last         = last_reg;

endmodule

`default_nettype wire
